### rtl/core/mal_pkg.sv
`default_nettype none

package mal_pkg;

    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        FUNC_ADD = 1'b0,
        FUNC_DEL = 1'b1
    } func_t;

endpackage

`default_nettype wire

### rtl/core/mal_ram.sv
`default_nettype none

module mal_ram
    import mal_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [ADDR_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output      logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem_reg [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/mal_cmp.sv
`default_nettype none

module mal_cmp
    import mal_pkg::*;
#(
    parameter int ADDRESS_BYTES = 6
)
(
    input  wire logic [ADDR_W-1:0] addr_a,
    input  wire logic [ADDR_W-1:0] addr_b,
    output      logic              hit
);

    // compare only the low ADDRESS_BYTES bytes, capped at the field width
    localparam int CMP_BITS = (8 * ADDRESS_BYTES > ADDR_W) ? ADDR_W : 8 * ADDRESS_BYTES;
    localparam logic [ADDR_W-1:0] CMP_MASK = {ADDR_W{1'b1}} >> (ADDR_W - CMP_BITS);

    assign hit = ((addr_a ^ addr_b) & CMP_MASK) == '0;

endmodule

`default_nettype wire

### rtl/core/multicast_address_list.sv
// Steps: IDLE takes a request; SCAN reads and compares the stored entries in order;
//   on a delete hit SHIFT moves the later entries down one slot; DONE loads the result.
//   Throughput: one request at a time, the next word is taken as soon as the result
//   is loaded into the output register; a full output register holds DONE and so stalls
//   the following request. One RAM with one write and one read port, one shared compare unit.
// Reset: entry count cleared; table contents undefined until written, no clearing pass.
`default_nettype none

module multicast_address_list
    import mal_pkg::*;
#(
    parameter int TABLE_DEPTH   = 16,
    parameter int ADDRESS_BYTES = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,   // [47:0] address
    input  wire logic              s_tuser,   // [0] func
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [OUT_W-1:0]  m_tdata    // [2:0] status, [7:3] entry_count,
                                              // [8] reload_request, [15:9] zero
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        DONE
    } state_t;

    state_t            state_reg, state_next;
    logic              func_reg, func_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              pend_reg, pend_next;
    status_t           res_status_reg, res_status_next;
    logic              res_reload_reg, res_reload_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ADDR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ADDR_W-1:0] ram_rdata;
    logic              hit;
    logic [CW-1:0]     wr_idx;
    logic [CW+COUNT_W-1:0] cnt_wide;

    mal_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mal_cmp #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_cmp (
        .addr_a (ram_rdata),
        .addr_b (addr_reg),
        .hit    (hit)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign cnt_wide = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_reload_next = res_reload_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        wr_idx          = count_reg;
        ram_wdata       = addr_reg;
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[AW-1:0];

        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = s_tuser;
                    addr_next   = s_tdata;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = SCAN;
                end
            end
            SCAN:
            begin
                if (pend_reg && hit)
                begin
                    pend_next = 1'b0;
                    if (func_reg == FUNC_ADD)
                    begin
                        res_status_next = ST_PRESENT;
                        res_reload_next = 1'b0;
                        state_next      = DONE;
                    end
                    else
                    begin
                        rd_idx_next = cmp_idx_reg + ONE_C;
                        state_next  = SHIFT;
                    end
                end
                else if (rd_idx_reg >= count_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = DONE;
                    if (func_reg == FUNC_DEL)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_reload_next = 1'b0;
                    end
                    else if (count_reg == DEPTH_C)
                    begin
                        res_status_next = ST_FULL;
                        res_reload_next = 1'b0;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        wr_idx          = count_reg;
                        ram_wdata       = addr_reg;
                        count_next      = count_reg + ONE_C;
                        res_status_next = ST_ADDED;
                        res_reload_next = 1'b1;
                    end
                end
                else
                begin
                    ram_re       = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    pend_next    = 1'b1;
                    rd_idx_next  = rd_idx_reg + ONE_C;
                end
            end
            SHIFT:
            begin
                // move the word read last cycle down one slot
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    wr_idx    = cmp_idx_reg - ONE_C;
                    ram_wdata = ram_rdata;
                end
                if (rd_idx_reg >= count_reg)
                begin
                    pend_next       = 1'b0;
                    count_next      = count_reg - ONE_C;
                    res_status_next = ST_DELETED;
                    res_reload_next = 1'b1;
                    state_next      = DONE;
                end
                else
                begin
                    ram_re       = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    pend_next    = 1'b1;
                    rd_idx_next  = rd_idx_reg + ONE_C;
                end
            end
            DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_W - 1 - COUNT_W - STATUS_W){1'b0}},
                                     res_reload_reg,
                                     cnt_wide[COUNT_W-1:0],
                                     res_status_reg};
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign ram_waddr = wr_idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            func_reg       <= FUNC_ADD;
            addr_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            pend_reg       <= 1'b0;
            res_status_reg <= ST_ADDED;
            res_reload_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            addr_reg       <= addr_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            pend_reg       <= pend_next;
            res_status_reg <= res_status_next;
            res_reload_reg <= res_reload_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == DONE))
        else $error("entry count changed outside a finished request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word while busy");

    a_shift_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == SHIFT) |-> (wr_idx < count_reg))
        else $error("shift write beyond occupied entries");

endmodule

`default_nettype wire

### tb/sv/tb_multicast_address_list.sv
`default_nettype none

module tb_multicast_address_list;
    import mal_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int ADDRESS_BYTES = 6;
    localparam int POOL_N        = 24;
    localparam int RANDOM_WORDS  = 267;
    localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [ADDR_W-1:0] MATCH_MASK =
        (ADDRESS_BYTES >= 6) ? '1 : ((48'd1 << (8 * ADDRESS_BYTES)) - 48'd1);

    typedef struct packed {
        func_t             func;
        logic [ADDR_W-1:0] addr;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               reload;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    request_t          pending_words[$];
    list_result_t      expected_results[$];
    logic [ADDR_W-1:0] list_addr[TABLE_DEPTH];
    int                list_count = 0;
    logic [ADDR_W-1:0] addr_pool[POOL_N];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    int words_in = 0;
    int words_out = 0;
    int status_seen[5] = '{default: 0};

    request_t     next_word;
    list_result_t got;
    list_result_t want;

    multicast_address_list #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .ADDRESS_BYTES(ADDRESS_BYTES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic list_result_t apply_request(func_t f, logic [ADDR_W-1:0] a);
        list_result_t r;
        int           slot;
        slot = list_count;
        for (int i = 0; i < list_count; i++)
        begin
            if (slot == list_count && ((list_addr[i] ^ a) & MATCH_MASK) == '0)
                slot = i;
        end
        r.reload = 1'b0;
        if (f == FUNC_ADD)
        begin
            if (slot < list_count)
                r.status = ST_PRESENT;
            else if (list_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                list_addr[list_count] = a;
                list_count++;
                r.status = ST_ADDED;
                r.reload = 1'b1;
            end
        end
        else
        begin
            if (slot >= list_count)
                r.status = ST_NOT_FOUND;
            else
            begin
                for (int i = slot + 1; i < list_count; i++)
                    list_addr[i-1] = list_addr[i];
                list_count--;
                r.status = ST_DELETED;
                r.reload = 1'b1;
            end
        end
        r.count = COUNT_W'(list_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        errors++;
        $display("[%0t] mismatch on word %0d: %s got %0d expected %0d",
                 $time, words_out, what, got_v, want_v);
    endtask

    task automatic push_word(func_t f, logic [ADDR_W-1:0] a);
        request_t w;
        w.func = f;
        w.addr = a;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // bursts lean toward add or delete so the list fills up and drains
    task automatic queue_random_words(int n);
        int                left;
        int                burst;
        int                add_pct;
        func_t             f;
        logic [ADDR_W-1:0] a;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(24, 8);
            add_pct = $urandom_range(1, 0) ? 85 : 15;
            for (int k = 0; k < burst && left > 0; k++)
            begin
                if ($urandom_range(99, 0) < 10)
                begin
                    f = $urandom_range(1, 0) ? FUNC_DEL : FUNC_ADD;
                    a = ADDR_W'({$urandom, $urandom});
                end
                else
                begin
                    f = ($urandom_range(99, 0) < add_pct) ? FUNC_ADD : FUNC_DEL;
                    a = addr_pool[$urandom_range(POOL_N - 1, 0)];
                end
                push_word(f, a);
                left--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(func_t'(s_tuser), s_tdata));
                words_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.addr;
                    s_tuser  <= next_word.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[2:0]);
                got.count  = m_tdata[7:3];
                got.reload = m_tdata[8];
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result word", int'(m_tdata), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.count != want.count)
                        report_mismatch("entry_count", got.count, want.count);
                    if (got.reload != want.reload)
                        report_mismatch("reload_request", got.reload, want.reload);
                    if (want.status <= ST_FULL)
                        status_seen[want.status]++;
                end
                words_out++;
            end
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    initial
    begin
        // half the pool is random, the other half differs from it in one byte
        for (int i = 0; i < POOL_N; i++)
        begin
            if (i < POOL_N / 2)
                addr_pool[i] = ADDR_W'({$urandom, $urandom});
            else
                addr_pool[i] = addr_pool[i - POOL_N / 2] ^ (48'hFF << (8 * (i % 6)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 54;

        push_word(FUNC_DEL, 48'h0);                 // delete on empty list
        push_word(FUNC_ADD, 48'hFFFF_FFFF_FFFF);
        push_word(FUNC_ADD, 48'h0);
        push_word(FUNC_ADD, 48'hFFFF_FFFF_FFFF);    // duplicate
        push_word(FUNC_ADD, 48'h0100_0000_0000);    // top byte only differs from zero
        push_word(FUNC_ADD, 48'h7FFF_FFFF_FFFF);    // top bit only differs from all ones
        for (int i = 0; i < 12; i++)
            push_word(FUNC_ADD, 48'h0100_5E00_0000 + i);
        push_word(FUNC_ADD, 48'h0000_0000_0001);    // list full, refused
        push_word(FUNC_ADD, 48'h0);                 // full but present
        push_word(FUNC_DEL, 48'h0100_0000_0000);    // middle entry
        push_word(FUNC_DEL, 48'h0100_0000_0000);    // already gone
        push_word(FUNC_DEL, 48'hFFFF_FFFF_FFFF);    // first entry
        push_word(FUNC_DEL, 48'h0100_5E00_000B);    // last entry
        push_word(FUNC_ADD, 48'h0100_0000_0000);
        wait_idle();

        queue_random_words(RANDOM_WORDS);
        wait_idle();

        send_idle_pct = 54;
        recv_idle_pct = 9;
        queue_random_words(RANDOM_WORDS);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_words(RANDOM_WORDS);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked in %0d cycles",
                 words_in, words_out, cycles);
        $display("added %0d, present %0d, deleted %0d, not found %0d, full %0d",
                 status_seen[ST_ADDED], status_seen[ST_PRESENT], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
